/* design/pol_pkg.sv */
package pol_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_DELETE   = 2'd1,
    MODE_CLEAR    = 2'd2,
    MODE_TRAVERSE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

/* design/pol_ram.sv */
// Entry store: one write port, one read port, registered read data.
module pol_ram #(
  parameter int unsigned DEPTH = pol_pkg::CAPACITY,
  parameter int unsigned WIDTH = pol_pkg::DATA_WIDTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/positional_ordered_list.sv */
// Positional ordered list of up to CAPACITY values kept in a single-port-style
// entry memory (one write, one registered read per cycle). Each request carries
// a mode in tuser (insert, delete, clear, traverse), a one-based position and a
// value. Insert, delete and clear return one result with status, new length and
// empty flag; traverse streams every entry in order with tlast on the final one
// (an empty list gives a single result). Requests are handled one at a time and
// s_axis_tready is low while a request is being worked. Insert and delete move
// the entries behind the position one at a time, one read/write pair per entry
// under a small sequencer; clear only resets the length, and any stall on the
// result side holds the request. A bad position or a full list goes straight to
// the result. No clearing pass after reset: entries are undefined until written
// and only the first length are ever read.
module positional_ordered_list #(
  parameter int unsigned CAPACITY   = pol_pkg::CAPACITY,
  parameter int unsigned DATA_WIDTH = pol_pkg::DATA_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [4:0] position, [36:5] value, [39:37] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] mode
  // result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] element, [36:32] length, [39:37] zero
  output logic [2:0]  m_axis_tuser,  // [1:0] status, [2] is_empty
  output logic        m_axis_tlast   // last
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // common width for position/length compares
  localparam int unsigned PW = ((CW > 5) ? CW : 5) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_GET,
    S_DEL_CHK,
    S_DEL_WR,
    S_TRV_RD,
    S_TRV_OUT,
    S_RESP
  } state_e;

  state_e                  state_q;
  logic [CW-1:0]           count_q;
  logic [PW-1:0]           idx_q;    // running index of the shift / traverse
  logic [PW-1:0]           pos_q;
  logic [DATA_WIDTH-1:0]   val_q;
  pol_pkg::status_e        res_status_q;
  logic [31:0]             res_elem_q;

  logic                    m_valid_q;
  pol_pkg::status_e        m_status_q;
  logic [31:0]             m_elem_q;
  logic [4:0]              m_len_q;
  logic                    m_empty_q;
  logic                    m_last_q;

  // request unpacking
  pol_pkg::mode_e          in_mode;
  logic [PW-1:0]           in_pos;
  logic [31:0]             in_value;
  logic [PW-1:0]           cnt_ext;
  logic                    out_free;
  logic                    res_load;

  assign in_mode  = pol_pkg::mode_e'(s_axis_tuser[1:0]);
  assign in_pos   = PW'(s_axis_tdata[4:0]);
  assign in_value = s_axis_tdata[36:5];
  assign cnt_ext  = PW'(count_q);
  assign out_free = !m_valid_q || m_axis_tready;
  // result register takes a new result this cycle
  assign res_load = out_free && (state_q == S_TRV_OUT || state_q == S_RESP);

  assign s_axis_tready = (state_q == S_IDLE);

  // memory port control
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [DATA_WIDTH-1:0]   mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;
  logic [DATA_WIDTH-1:0]   mem_rdata;
  logic [PW-1:0]           pos_m1;
  logic [PW-1:0]           idx_m1;

  assign pos_m1 = pos_q - PW'(1);
  assign idx_m1 = idx_q - PW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(idx_q);
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = AW'(idx_q);
    case (state_q)
      S_INS_CHK: begin
        if (idx_q == pos_m1) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pos_m1);
          mem_wdata = val_q;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_m1);
        end
      end
      S_INS_WR: begin
        mem_we = 1'b1;
      end
      S_DEL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(pos_m1);
      end
      S_DEL_CHK: begin
        mem_re = (idx_q != cnt_ext);
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_m1);
      end
      S_TRV_RD: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  pol_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      m_valid_q    <= 1'b0;
      idx_q        <= '0;
      pos_q        <= '0;
      val_q        <= '0;
      res_status_q <= pol_pkg::ST_OK;
      res_elem_q   <= '0;
      m_status_q   <= pol_pkg::ST_OK;
      m_elem_q     <= '0;
      m_len_q      <= '0;
      m_empty_q    <= 1'b1;
      m_last_q     <= 1'b0;
    end else begin
      if (res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pos_q      <= in_pos;
            val_q      <= DATA_WIDTH'($unsigned(in_value));
            res_elem_q <= '0;
            case (in_mode)
              pol_pkg::MODE_INSERT: begin
                if (in_pos == '0 || in_pos > cnt_ext + PW'(1)) begin
                  res_status_q <= pol_pkg::ST_RANGE;
                  state_q      <= S_RESP;
                end else if (cnt_ext == PW'(CAPACITY)) begin
                  res_status_q <= pol_pkg::ST_FULL;
                  state_q      <= S_RESP;
                end else begin
                  res_status_q <= pol_pkg::ST_OK;
                  idx_q        <= cnt_ext;
                  state_q      <= S_INS_CHK;
                end
              end
              pol_pkg::MODE_DELETE: begin
                if (in_pos == '0 || in_pos > cnt_ext) begin
                  res_status_q <= pol_pkg::ST_RANGE;
                  state_q      <= S_RESP;
                end else begin
                  res_status_q <= pol_pkg::ST_OK;
                  state_q      <= S_DEL_RD;
                end
              end
              pol_pkg::MODE_CLEAR: begin
                count_q      <= '0;
                res_status_q <= pol_pkg::ST_OK;
                state_q      <= S_RESP;
              end
              default: begin
                res_status_q <= pol_pkg::ST_OK;
                idx_q        <= '0;
                state_q      <= (count_q == '0) ? S_RESP : S_TRV_RD;
              end
            endcase
          end
        end
        S_INS_CHK: begin
          if (idx_q == pos_m1) begin
            count_q <= count_q + CW'(1);
            state_q <= S_RESP;
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          idx_q   <= idx_m1;
          state_q <= S_INS_CHK;
        end
        S_DEL_RD: begin
          state_q <= S_DEL_GET;
        end
        S_DEL_GET: begin
          res_elem_q <= 32'(mem_rdata);
          idx_q      <= pos_q;
          state_q    <= S_DEL_CHK;
        end
        S_DEL_CHK: begin
          if (idx_q == cnt_ext) begin
            count_q <= count_q - CW'(1);
            state_q <= S_RESP;
          end else begin
            state_q <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          idx_q   <= idx_q + PW'(1);
          state_q <= S_DEL_CHK;
        end
        S_TRV_RD: begin
          state_q <= S_TRV_OUT;
        end
        S_TRV_OUT: begin
          if (out_free) begin
            m_status_q <= pol_pkg::ST_OK;
            m_elem_q   <= 32'(mem_rdata);
            m_len_q    <= 5'(count_q);
            m_empty_q  <= 1'b0;
            m_last_q   <= (idx_q + PW'(1) == cnt_ext);
            if (idx_q + PW'(1) == cnt_ext) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + PW'(1);
              state_q <= S_TRV_RD;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            m_status_q <= res_status_q;
            m_elem_q   <= res_elem_q;
            m_len_q    <= 5'(count_q);
            m_empty_q  <= (count_q == '0);
            m_last_q   <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_len_q, m_elem_q};
  assign m_axis_tuser  = {m_empty_q, m_status_q};
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(count_q) <= PW'(CAPACITY))
    else $error("list length above capacity");

  a_write_in_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> PW'(mem_waddr) <= cnt_ext)
    else $error("entry write beyond end of list");

  a_error_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] != pol_pkg::ST_OK) |-> m_axis_tlast)
    else $error("error result not marked last");

  a_empty_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata[36:32] == 5'd0)
    else $error("empty flag with non-zero length");
`endif

endmodule
